[design/pdl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdl_pkg
// Shared constants, register codes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package pdl_pkg;

	localparam int COORD_WIDTH  = 32;
	localparam int ANGLE_WIDTH  = 16;
	localparam int CORDIC_STEPS = 30;
	localparam int ROT_W        = 33;   // CORDIC x, y and residual angle width
	localparam int MAG_W        = 32;   // magnitude of cos / sin
	localparam int FRAC_BITS    = 30;   // Q2.30 cos / sin

	localparam logic signed [ROT_W-1:0] CORDIC_GAIN = 33'sd652032874;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int THRESH_W   = 16;
	localparam int TOL_W      = 14;

	localparam logic [CFG_IDX_W-1:0] CFG_DIST_THRESH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_TOL   = 2'd1;

	localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd1;
	localparam logic [TOL_W-1:0]    TOL_RESET    = 14'd16;

	// arctan(2^-i) in units of pi/2^31
	function automatic logic [31:0] atan_unit(input int i);
		logic [31:0] t;
		unique case (i)
			0:  t = 32'h20000000;
			1:  t = 32'h12E4051D;
			2:  t = 32'h09FB385B;
			3:  t = 32'h051111D4;
			4:  t = 32'h028B0D43;
			5:  t = 32'h0145D7E1;
			6:  t = 32'h00A2F61E;
			7:  t = 32'h00517C55;
			8:  t = 32'h0028BE53;
			9:  t = 32'h00145F2E;
			10: t = 32'h000A2F98;
			11: t = 32'h000517CC;
			12: t = 32'h00028BE6;
			13: t = 32'h000145F3;
			14: t = 32'h0000A2F9;
			15: t = 32'h0000517C;
			16: t = 32'h000028BE;
			17: t = 32'h0000145F;
			18: t = 32'h00000A2F;
			19: t = 32'h00000517;
			20: t = 32'h0000028B;
			21: t = 32'h00000145;
			22: t = 32'h000000A2;
			23: t = 32'h00000051;
			24: t = 32'h00000028;
			25: t = 32'h00000014;
			26: t = 32'h0000000A;
			27: t = 32'h00000005;
			28: t = 32'h00000002;
			29: t = 32'h00000001;
			default: t = 32'h0;
		endcase
		return t;
	endfunction

endpackage

[design/pdl_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdl_in_if / pdl_out_if
// Valid/ready channels for the input word and the result word.
// ----------------------------------------------------------------------------
interface pdl_in_if #(
	parameter int COORD_WIDTH = pdl_pkg::COORD_WIDTH,
	parameter int ANGLE_WIDTH = pdl_pkg::ANGLE_WIDTH
);
	logic                          valid;
	logic                          ready;
	logic signed [ANGLE_WIDTH-1:0] angle;
	logic signed [COORD_WIDTH-1:0] center_x;
	logic signed [COORD_WIDTH-1:0] center_y;
	logic        [COORD_WIDTH-2:0] distance;

	modport source (output valid, angle, center_x, center_y, distance, input ready);
	modport sink   (input valid, angle, center_x, center_y, distance, output ready);
endinterface

interface pdl_out_if #(
	parameter int COORD_WIDTH = pdl_pkg::COORD_WIDTH
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] first_x;
	logic signed [COORD_WIDTH-1:0] first_y;
	logic signed [COORD_WIDTH-1:0] second_x;
	logic signed [COORD_WIDTH-1:0] second_y;

	modport source (output valid, first_x, first_y, second_x, second_y, input ready);
	modport sink   (input valid, first_x, first_y, second_x, second_y, output ready);
endinterface

[design/pdl_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdl_front
// Holds the config registers, classifies each word (short, vertical) and
// folds the angle into [-pi/2, +pi/2] as a CORDIC residual angle.
// ----------------------------------------------------------------------------
module pdl_front #(
	parameter int COORD_WIDTH = pdl_pkg::COORD_WIDTH,
	parameter int ANGLE_WIDTH = pdl_pkg::ANGLE_WIDTH,
	parameter int PW          = 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [pdl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pdl_pkg::CFG_DATA_W-1:0] cfg_data,
	pdl_in_if.sink                         in_ch,
	output logic                           f_valid,
	input  logic                           f_ready,
	output logic [PW-1:0]                  f_data
);
	localparam int AW   = ANGLE_WIDTH;
	localparam int CW   = COORD_WIDTH;
	localparam int ZW   = pdl_pkg::ROT_W;
	localparam int CMPW = (AW + 1 > pdl_pkg::TOL_W) ? AW + 1 : pdl_pkg::TOL_W;
	localparam int TW   = (CW - 1 > pdl_pkg::THRESH_W) ? CW - 1 : pdl_pkg::THRESH_W;
	localparam logic signed [AW:0] HALF = (AW+1)'(1 << (AW - 2));
	localparam logic signed [AW:0] FULL = (AW+1)'(1 << (AW - 1));

	logic [pdl_pkg::THRESH_W-1:0] thresh_q;
	logic [pdl_pkg::TOL_W-1:0]    tol_q;
	logic                         valid_s1;
	logic [PW-1:0]                data_s1;

	logic signed [AW:0]  a_ext, diff, r;
	logic        [AW:0]  adiff;
	logic signed [ZW-1:0] z;
	logic                short_d, vert;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= pdl_pkg::THRESH_RESET;
			tol_q    <= pdl_pkg::TOL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pdl_pkg::CFG_DIST_THRESH: thresh_q <= cfg_data[pdl_pkg::THRESH_W-1:0];
				pdl_pkg::CFG_ANGLE_TOL:   tol_q    <= cfg_data[pdl_pkg::TOL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		a_ext = {in_ch.angle[AW-1], in_ch.angle};
		diff  = a_ext - HALF;
		adiff = diff[AW] ? unsigned'(-diff) : unsigned'(diff);
		vert  = CMPW'(adiff) < CMPW'(tol_q);
		short_d = TW'(in_ch.distance) < TW'(thresh_q);
		if (a_ext > HALF)
			r = a_ext - FULL;
		else if (a_ext < -HALF)
			r = a_ext + FULL;
		else
			r = a_ext;
		z = ZW'(r) <<< (32 - AW);
	end

	assign in_ch.ready = !valid_s1 || f_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ch.ready)
			valid_s1 <= in_ch.valid;
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid)
			data_s1 <= {z, in_ch.center_x, in_ch.center_y, in_ch.distance, short_d, vert};
	end

	assign f_valid = valid_s1;
	assign f_data  = data_s1;
endmodule

[design/pdl_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdl_queue
// Two-entry queue between the classifier and the CORDIC datapath.
// ----------------------------------------------------------------------------
module pdl_queue #(
	parameter int PW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  logic [PW-1:0] push_data,
	output logic          pop_valid,
	input  logic          pop_ready,
	output logic [PW-1:0] pop_data
);
	logic [PW-1:0] mem_q [2];
	logic          wptr_q, rptr_q;
	logic [1:0]    count_q;
	logic          push, pop;

	assign push_ready = count_q != 2'd2;
	assign pop_valid  = count_q != 2'd0;
	assign pop_data   = mem_q[rptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wptr_q <= !wptr_q;
			if (pop)  rptr_q <= !rptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wptr_q] <= push_data;
	end
endmodule

[design/pdl_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdl_back
// Unrolled 30-step CORDIC, distance scaling, center add and saturation.
// The whole pipeline advances together unless the result word is held.
// ----------------------------------------------------------------------------
module pdl_back #(
	parameter int COORD_WIDTH = pdl_pkg::COORD_WIDTH,
	parameter int PW          = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	output logic            q_ready,
	input  logic [PW-1:0]   q_data,
	pdl_out_if.source       out_ch
);
	localparam int CW  = COORD_WIDTH;
	localparam int ZW  = pdl_pkg::ROT_W;
	localparam int XW  = pdl_pkg::ROT_W;
	localparam int MW  = pdl_pkg::MAG_W;
	localparam int FB  = pdl_pkg::FRAC_BITS;
	localparam int NS  = pdl_pkg::CORDIC_STEPS;
	localparam int LO  = (CW - 1) / 2;
	localparam int HI  = CW - 1 - LO;
	localparam int SW  = CW - 1 + MW + 1;
	localparam int OW  = CW + 1;
	localparam int NV  = NS + 4;
	// stage indexes: 0 load, 1..NS CORDIC, NS+1 products, NS+2 offsets, NS+3 out
	localparam int SM1 = NS + 1;
	localparam int SM2 = NS + 2;
	localparam int SO  = NS + 3;

	logic              en;
	logic              v_s [NV];
	logic signed [XW-1:0] x_s [NS+1];
	logic signed [XW-1:0] y_s [NS+1];
	logic signed [ZW-1:0] z_s [NS+1];
	logic signed [CW-1:0] cx_s [SM2+1];
	logic signed [CW-1:0] cy_s [SM2+1];
	logic        [CW-2:0] d_s  [SM2+1];
	logic                 short_s [SM2+1];
	logic                 vert_s  [SM2+1];

	logic [LO+MW-1:0] pcl_s, psl_s;
	logic [HI+MW-1:0] pch_s, psh_s;
	logic             negc_s, negs_s;
	logic signed [OW-1:0] ox_s, oy_s;
	logic signed [CW-1:0] fx_s, fy_s, sx_s, sy_s;

	logic [MW-1:0] magc, mags;
	logic [SW-1:0] sumc, sums;
	logic signed [OW-1:0] oxc, oyc;

	assign en      = !v_s[SO] || out_ch.ready;
	assign q_ready = en;

	function automatic logic signed [CW-1:0] sat(input logic signed [CW+1:0] v);
		logic signed [CW-1:0] res;
		if (v[CW+1:CW-1] == 3'b000 || v[CW+1:CW-1] == 3'b111)
			res = v[CW-1:0];
		else
			res = v[CW+1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
		return res;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NV; k++)
				v_s[k] <= 1'b0;
		end else if (en) begin
			v_s[0] <= q_valid;
			for (int k = 1; k < NV; k++)
				v_s[k] <= v_s[k-1];
		end
	end

	// load stage; word layout {z, cx, cy, d, short, vert}
	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]     <= pdl_pkg::CORDIC_GAIN;
			y_s[0]     <= '0;
			z_s[0]     <= q_data[PW-1 -: ZW];
			cx_s[0]    <= q_data[PW-ZW-1 -: CW];
			cy_s[0]    <= q_data[PW-ZW-CW-1 -: CW];
			d_s[0]     <= q_data[CW:2];
			short_s[0] <= q_data[1];
			vert_s[0]  <= q_data[0];
		end
	end

	for (genvar i = 0; i < NS; i++) begin : g_rot
		logic signed [ZW-1:0] at;
		assign at = ZW'(signed'({1'b0, pdl_pkg::atan_unit(i)}));
		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_s[i][ZW-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - at;
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + at;
				end
			end
		end
	end

	for (genvar k = 0; k < SM2; k++) begin : g_side
		always_ff @(posedge clk) begin
			if (en) begin
				cx_s[k+1]    <= cx_s[k];
				cy_s[k+1]    <= cy_s[k];
				d_s[k+1]     <= d_s[k];
				short_s[k+1] <= short_s[k];
				vert_s[k+1]  <= vert_s[k];
			end
		end
	end

	// partial products of distance by |cos|, |sin|
	always_comb begin
		magc = MW'(x_s[NS][XW-1] ? -x_s[NS] : x_s[NS]);
		mags = MW'(y_s[NS][XW-1] ? -y_s[NS] : y_s[NS]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pcl_s  <= d_s[NS][LO-1:0] * magc;
			pch_s  <= d_s[NS][CW-2:LO] * magc;
			psl_s  <= d_s[NS][LO-1:0] * mags;
			psh_s  <= d_s[NS][CW-2:LO] * mags;
			negc_s <= x_s[NS][XW-1];
			negs_s <= y_s[NS][XW-1];
		end
	end

	// round half away from zero on magnitude, then restore sign; short words get a zero offset, vertical words (0, d)
	always_comb begin
		sumc = (SW'(pch_s) << LO) + SW'(pcl_s) + (SW'(1) << (FB - 1));
		sums = (SW'(psh_s) << LO) + SW'(psl_s) + (SW'(1) << (FB - 1));
		if (short_s[SM1]) begin
			oxc = '0;
			oyc = '0;
		end else if (vert_s[SM1]) begin
			oxc = '0;
			oyc = signed'({2'b00, d_s[SM1]});
		end else begin
			oxc = negc_s ? -signed'({1'b0, sumc[FB +: CW]}) : signed'({1'b0, sumc[FB +: CW]});
			oyc = negs_s ? -signed'({1'b0, sums[FB +: CW]}) : signed'({1'b0, sums[FB +: CW]});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ox_s <= oxc;
			oy_s <= oyc;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fx_s <= sat((CW+2)'(cx_s[SM2]) + (CW+2)'(ox_s));
			fy_s <= sat((CW+2)'(cy_s[SM2]) + (CW+2)'(oy_s));
			sx_s <= sat((CW+2)'(cx_s[SM2]) - (CW+2)'(ox_s));
			sy_s <= sat((CW+2)'(cy_s[SM2]) - (CW+2)'(oy_s));
		end
	end

	assign out_ch.valid    = v_s[SO];
	assign out_ch.first_x  = fx_s;
	assign out_ch.first_y  = fy_s;
	assign out_ch.second_x = sx_s;
	assign out_ch.second_y = sy_s;
endmodule

[design/points_at_distance_on_line.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// points_at_distance_on_line
// Two points on a line through a center, a given distance either side.
// ----------------------------------------------------------------------------
// Takes one word per clock while no held result stalls the pipeline, and
// returns one result word per input word, in order. Each word passes one
// classify register, the two-entry queue, a load stage, 30 unrolled CORDIC
// rotation stages, a product stage, an offset stage and the output register.
// The CORDIC pipeline advances as a whole, so a held result stalls it; the
// queue keeps the front accepting for two more words. Config (index 0 distance
// threshold, index 1 vertical angle tolerance) should be written when idle.
module points_at_distance_on_line #(
	parameter int COORD_WIDTH = pdl_pkg::COORD_WIDTH,
	parameter int ANGLE_WIDTH = pdl_pkg::ANGLE_WIDTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [pdl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pdl_pkg::CFG_DATA_W-1:0] cfg_data,
	pdl_in_if.sink                         in_ch,
	pdl_out_if.source                      out_ch
);
	localparam int PW = pdl_pkg::ROT_W + 3 * COORD_WIDTH - 1 + 2;

	logic          f_valid, f_ready, q_valid, q_ready;
	logic [PW-1:0] f_data, q_data;

	pdl_front #(.COORD_WIDTH(COORD_WIDTH), .ANGLE_WIDTH(ANGLE_WIDTH), .PW(PW)) u_front (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data, .in_ch,
		.f_valid, .f_ready, .f_data
	);

	pdl_queue #(.PW(PW)) u_queue (
		.clk, .arst_n,
		.push_valid(f_valid), .push_ready(f_ready), .push_data(f_data),
		.pop_valid(q_valid), .pop_ready(q_ready), .pop_data(q_data)
	);

	pdl_back #(.COORD_WIDTH(COORD_WIDTH), .PW(PW)) u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_data, .out_ch
	);
endmodule
